// ----- hdl/bayer_bilinear_demosaic_macros.svh -----
// Assertion macros shared by the demosaic RTL.
`ifndef BAYER_BILINEAR_DEMOSAIC_MACROS_SVH
`define BAYER_BILINEAR_DEMOSAIC_MACROS_SVH
`ifndef SYNTH
`define BBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bbd assertion failed");
`define BBD_ASSERT_NEXT(lbl, cause, effect) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("bbd assertion failed");
`else
`define BBD_ASSERT(lbl, prop)
`define BBD_ASSERT_NEXT(lbl, cause, effect)
`endif
`endif

// ----- hdl/bbd_pkg.sv -----
package bbd_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
  localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 3);

  // per-channel sums of up to five samples
  localparam int SUM_W        = PIX_W + 3;
  localparam int CNT_W        = 3;
  localparam int RECIP3_SHIFT = 11;
  localparam int RECIP5_SHIFT = 13;
  localparam int RECIP3       = (2 ** RECIP3_SHIFT + 2) / 3;
  localparam int RECIP5       = (2 ** RECIP5_SHIFT + 3) / 5;
  localparam int RECIP_W      = $clog2(RECIP5 + 1);
  localparam int PROD_W       = SUM_W + RECIP_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } bbd_state_t;

  typedef enum logic [1:0] {
    COLOR_GREEN,
    COLOR_RED,
    COLOR_BLUE
  } bbd_color_t;

  typedef struct packed {
    logic take;
    logic load;
    logic emit;
  } bbd_cmd_t;

  typedef struct packed {
    logic skip;
    logic pixel;
    logic out_free;
  } bbd_status_t;

endpackage

// ----- hdl/bbd_ram.sv -----
module bbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/bbd_ctrl.sv -----
`include "bayer_bilinear_demosaic_macros.svh"

module bbd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bbd_pkg::bbd_status_t status,
  output bbd_pkg::bbd_cmd_t    cmd
);
  import bbd_pkg::*;

  bbd_state_t state;
  bbd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !status.skip) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        state_next = status.pixel ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid && !status.skip;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  `BBD_ASSERT_NEXT(a_take_then_load, cmd.take, state == ST_LOAD)
  `BBD_ASSERT_NEXT(a_empty_load_idle, cmd.load && !status.pixel, state == ST_IDLE)
  `BBD_ASSERT_NEXT(a_emit_then_idle, cmd.emit, state == ST_IDLE)

endmodule

// ----- hdl/bbd_datapath.sv -----
`include "bayer_bilinear_demosaic_macros.svh"

module bbd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bbd_pkg::CFG_W-1:0]           cfg_data,
  input  logic [bbd_pkg::PIX_W-1:0]           sample,
  input  logic                                flush,
  input  bbd_pkg::bbd_cmd_t                   cmd,
  output bbd_pkg::bbd_status_t                status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bbd_pkg::PIX_W-1:0]           red,
  output logic [bbd_pkg::PIX_W-1:0]           green,
  output logic [bbd_pkg::PIX_W-1:0]           blue,
  output logic                                end_of_line,
  output logic                                end_of_frame
);
  import bbd_pkg::*;

  function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
    logic [WID_W-1:0] r;
    if (int'(v) < 2) r = WID_W'(2);
    else if (int'(v) > MAX_WIDTH) r = WID_W'(MAX_WIDTH);
    else r = WID_W'(v);
    return r;
  endfunction

  function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
    logic [HGT_W-1:0] r;
    if (int'(v) < 2) r = HGT_W'(2);
    else if (int'(v) > MAX_HEIGHT) r = HGT_W'(MAX_HEIGHT);
    else r = HGT_W'(v);
    return r;
  endfunction

  function automatic bbd_color_t site_color(input logic row_odd, input logic col_odd);
    bbd_color_t c;
    if (!row_odd && col_odd) c = COLOR_BLUE;
    else if (row_odd && !col_odd) c = COLOR_RED;
    else c = COLOR_GREEN;
    return c;
  endfunction

  // truncated mean; thirds and fifths by reciprocal multiply
  function automatic logic [PIX_W-1:0] mean_of(input logic [SUM_W-1:0] s,
                                               input logic [CNT_W-1:0] n);
    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0]  q;
    prod = PROD_W'(s) * ((n == CNT_W'(3)) ? PROD_W'(RECIP3) : PROD_W'(RECIP5));
    unique case (n)
      CNT_W'(1): q = PIX_W'(s);
      CNT_W'(2): q = PIX_W'(s >> 1);
      CNT_W'(3): q = PIX_W'(prod >> RECIP3_SHIFT);
      CNT_W'(4): q = PIX_W'(s >> 2);
      CNT_W'(5): q = PIX_W'(prod >> RECIP5_SHIFT);
      default:   q = '0;
    endcase
    return q;
  endfunction

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [COL_W-1:0] in_column;
  logic [ROW_W-1:0] in_row;

  logic [WID_W-1:0] width_used;
  logic [HGT_W-1:0] height_used;
  logic [ROW_W-1:0] h_row;
  logic [COL_W-1:0] col_cur;
  logic [WID_W-1:0] col_inc;
  logic             draining;
  logic             pix_a_cur;
  logic             pix_b_cur;
  logic             last_cur;
  logic [ROW_W-1:0] pr_cur;
  logic [COL_W-1:0] pc_cur;
  logic [COL_W-1:0] in_column_next;
  logic [ROW_W-1:0] in_row_next;

  assign width_used  = clamp_width(image_width);
  assign height_used = clamp_height(image_height);
  assign h_row       = ROW_W'(height_used);
  assign col_cur     = (WID_W'(in_column) >= width_used) ? '0 : in_column;
  assign col_inc     = WID_W'(col_cur) + WID_W'(1);
  assign draining    = in_row >= h_row;
  assign pix_a_cur   = (col_cur == '0) && (in_row >= ROW_W'(2));
  assign pix_b_cur   = (col_cur != '0) && (in_row != '0) && (in_row <= h_row);
  assign last_cur    = pix_a_cur && (in_row == h_row + ROW_W'(1));
  assign pr_cur      = pix_a_cur ? in_row - ROW_W'(2) : in_row - ROW_W'(1);
  assign pc_cur      = pix_a_cur ? COL_W'(width_used - WID_W'(1)) : col_cur - COL_W'(1);

  always_comb begin
    if (col_inc >= width_used) begin
      in_column_next = '0;
      in_row_next    = in_row + ROW_W'(1);
    end else begin
      in_column_next = COL_W'(col_inc);
      in_row_next    = in_row;
    end
    if (last_cur || (in_row_next > h_row + ROW_W'(1))) begin
      in_column_next = '0;
      in_row_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
      in_column    <= '0;
      in_row       <= '0;
    end else if (cfg_valid && (cfg_index == REG_IMAGE_WIDTH)) begin
      image_width <= cfg_data;
      in_column   <= '0;
      in_row      <= '0;
    end else if (cfg_valid && (cfg_index == REG_IMAGE_HEIGHT)) begin
      image_height <= cfg_data;
      in_column    <= '0;
      in_row       <= '0;
    end else if (cmd.take) begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
    end
  end

  logic [PIX_W-1:0] smp_q;
  logic [COL_W-1:0] addr_q;
  logic             pix_a_q;
  logic             pix_b_q;
  logic             eof_q;
  logic [ROW_W-1:0] pr_q;
  logic [COL_W-1:0] pc_q;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      smp_q   <= draining ? '0 : sample;
      addr_q  <= col_cur;
      pix_a_q <= pix_a_cur;
      pix_b_q <= pix_b_cur;
      eof_q   <= last_cur;
      pr_q    <= pr_cur;
      pc_q    <= pc_cur;
    end
  end

  // line store: upper byte older row, lower byte newer row
  logic [2*PIX_W-1:0] ls_rd_data;

  bbd_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (cmd.load),
    .wr_addr (addr_q),
    .wr_data ({ls_rd_data[PIX_W-1:0], smp_q}),
    .rd_en   (cmd.take),
    .rd_addr (col_cur),
    .rd_data (ls_rd_data)
  );

  logic [PIX_W-1:0] window    [9];
  logic [PIX_W-1:0] win_shift [9];
  logic [PIX_W-1:0] win_sel   [9];

  always_comb begin
    win_shift[0] = window[1];
    win_shift[1] = window[2];
    win_shift[2] = ls_rd_data[2*PIX_W-1:PIX_W];
    win_shift[3] = window[4];
    win_shift[4] = window[5];
    win_shift[5] = ls_rd_data[PIX_W-1:0];
    win_shift[6] = window[7];
    win_shift[7] = window[8];
    win_shift[8] = smp_q;
  end

  // right-edge pixel uses the window before the shift
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      win_sel[i] = pix_a_q ? window[i] : win_shift[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        window[i] <= '0;
      end
    end else if (cmd.load) begin
      for (int i = 0; i < 9; i++) begin
        window[i] <= win_shift[i];
      end
    end
  end

  logic [2:0] row_ok;
  logic [2:0] col_ok;
  logic [2:0] row_odd;
  logic [2:0] col_odd;

  always_comb begin
    row_ok[0]  = pr_q != '0;
    row_ok[1]  = 1'b1;
    row_ok[2]  = (pr_q + ROW_W'(1)) < h_row;
    col_ok[0]  = pix_a_q ? (WID_W'(pc_q) >= WID_W'(2)) : (pc_q != '0);
    col_ok[1]  = 1'b1;
    col_ok[2]  = pix_a_q ? 1'b1 : ((WID_W'(pc_q) + WID_W'(1)) < width_used);
    row_odd[0] = !pr_q[0];
    row_odd[1] = pr_q[0];
    row_odd[2] = !pr_q[0];
    col_odd[0] = pix_a_q ? pc_q[0] : !pc_q[0];
    col_odd[1] = pix_a_q ? !pc_q[0] : pc_q[0];
    col_odd[2] = pix_a_q ? pc_q[0] : !pc_q[0];
  end

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_g;
  logic [SUM_W-1:0] sum_b;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_g;
  logic [CNT_W-1:0] cnt_b;

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    cnt_r = '0;
    cnt_g = '0;
    cnt_b = '0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_ok[k] && col_ok[j]) begin
          unique case (site_color(row_odd[k], col_odd[j]))
            COLOR_BLUE: begin
              sum_b = sum_b + SUM_W'(win_sel[k*3+j]);
              cnt_b = cnt_b + CNT_W'(1);
            end
            COLOR_RED: begin
              sum_r = sum_r + SUM_W'(win_sel[k*3+j]);
              cnt_r = cnt_r + CNT_W'(1);
            end
            default: begin
              sum_g = sum_g + SUM_W'(win_sel[k*3+j]);
              cnt_g = cnt_g + CNT_W'(1);
            end
          endcase
        end
      end
    end
  end

  logic [SUM_W-1:0] sum_r_q;
  logic [SUM_W-1:0] sum_g_q;
  logic [SUM_W-1:0] sum_b_q;
  logic [CNT_W-1:0] cnt_r_q;
  logic [CNT_W-1:0] cnt_g_q;
  logic [CNT_W-1:0] cnt_b_q;
  logic [PIX_W-1:0] own_q;
  bbd_color_t       own_color_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum_r_q     <= sum_r;
      sum_g_q     <= sum_g;
      sum_b_q     <= sum_b;
      cnt_r_q     <= cnt_r;
      cnt_g_q     <= cnt_g;
      cnt_b_q     <= cnt_b;
      own_q       <= pix_a_q ? win_sel[5] : win_sel[4];
      own_color_q <= site_color(pr_q[0], pc_q[0]);
    end
  end

  logic [PIX_W-1:0] red_next;
  logic [PIX_W-1:0] green_next;
  logic [PIX_W-1:0] blue_next;

  assign red_next   = (own_color_q == COLOR_RED)   ? own_q : mean_of(sum_r_q, cnt_r_q);
  assign green_next = (own_color_q == COLOR_GREEN) ? own_q : mean_of(sum_g_q, cnt_g_q);
  assign blue_next  = (own_color_q == COLOR_BLUE)  ? own_q : mean_of(sum_b_q, cnt_b_q);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      red          <= red_next;
      green        <= green_next;
      blue         <= blue_next;
      end_of_line  <= pix_a_q;
      end_of_frame <= eof_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.skip     = flush && !draining;
  assign status.pixel    = pix_a_q || pix_b_q;
  assign status.out_free = !out_valid || !out_stall;

  `BBD_ASSERT_NEXT(a_emit_sets_valid, cmd.emit, out_valid)
  `BBD_ASSERT(a_eof_restart, (cmd.emit && eof_q) |-> (in_row == '0 && in_column == '0))
  `BBD_ASSERT(a_one_site, (cmd.load) |-> !(pix_a_q && pix_b_q))

endmodule

// ----- hdl/bayer_bilinear_demosaic.sv -----
// channel  dir  handshake            payload
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
// in       in   in_valid/in_stall    sample, flush
// out      out  out_valid/out_stall  red, green, blue, end_of_line, end_of_frame
//
// An item with a pixel goes through accept and line store read, window update
// and write-back, then mean and output load, which waits while a pixel is
// stalled. One without a pixel ends at write-back, an ignored flush at accept.
// Synchronous reset: 640x480, positions and window cleared; line store not cleared.
// A pixel waits in the output register while the next item is taken and loaded.
// cfg_ready is always high; a register write restarts the frame.
module bayer_bilinear_demosaic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bbd_pkg::PIX_W-1:0]     sample,
  input  logic                          flush,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bbd_pkg::PIX_W-1:0]     red,
  output logic [bbd_pkg::PIX_W-1:0]     green,
  output logic [bbd_pkg::PIX_W-1:0]     blue,
  output logic                          end_of_line,
  output logic                          end_of_frame
);
  import bbd_pkg::*;

  bbd_cmd_t    cmd;
  bbd_status_t status;

  assign cfg_ready = 1'b1;

  bbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bbd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .flush        (flush),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame)
  );

endmodule
